FILE: hw/rtl/rpg_pkg.sv
// ----------------------------------------------------------------------------
// rpg_pkg
// Shared types and constants of the rumble pattern generator.
// ----------------------------------------------------------------------------
package rpg_pkg;

  localparam int LEVEL_BITS       = 16;
  localparam int PHASE_BITS       = 16;
  localparam int FACTOR_BITS      = 17;
  localparam int COS_ENTRIES_DFLT = 256;
  localparam int CFG_ADDR_W       = 4;
  localparam int CFG_DATA_W       = 32;

  localparam logic [PHASE_BITS-1:0]  PERIOD_RESET = 16'd500;
  localparam logic [FACTOR_BITS-1:0] FACTOR_ONE   = 17'h10000;

  typedef enum logic [2:0] {
    MODE_OFF        = 3'd0,
    MODE_CONST      = 3'd1,
    MODE_SYNC_PULSE = 3'd2,
    MODE_ALT_PULSE  = 3'd3,
    MODE_SYNC_WAVE  = 3'd4,
    MODE_ALT_WAVE   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_PERIOD    = 2'd1,
    REG_LEVEL_ON  = 2'd2,
    REG_LEVEL_OFF = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_DIV,
    S_ROM,
    S_MUL_L,
    S_MUL_R,
    S_ADD_R,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]            mode;
    logic [PHASE_BITS-1:0] period_ms;
    logic [LEVEL_BITS-1:0] level_on;
    logic [LEVEL_BITS-1:0] level_off;
  } cfg_t;

endpackage

FILE: hw/rtl/rpg_cfg.sv
// ----------------------------------------------------------------------------
// rpg_cfg
// APB register file: mode, period and the two levels.
// ----------------------------------------------------------------------------
module rpg_cfg import rpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [2:0]            mode_r, mode_nxt;
  logic [PHASE_BITS-1:0] period_r, period_nxt;
  logic [LEVEL_BITS-1:0] level_on_r, level_on_nxt;
  logic [LEVEL_BITS-1:0] level_off_r, level_off_nxt;
  logic                  wr;
  reg_idx_t              idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_comb begin
    mode_nxt      = mode_r;
    period_nxt    = period_r;
    level_on_nxt  = level_on_r;
    level_off_nxt = level_off_r;
    if (wr) begin
      unique case (idx)
        REG_MODE:      mode_nxt      = pwdata[2:0];
        REG_PERIOD:    period_nxt    = pwdata[PHASE_BITS-1:0];
        REG_LEVEL_ON:  level_on_nxt  = pwdata[LEVEL_BITS-1:0];
        REG_LEVEL_OFF: level_off_nxt = pwdata[LEVEL_BITS-1:0];
        default:       mode_nxt      = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      period_r    <= PERIOD_RESET;
      level_on_r  <= '0;
      level_off_r <= '0;
    end else begin
      mode_r      <= mode_nxt;
      period_r    <= period_nxt;
      level_on_r  <= level_on_nxt;
      level_off_r <= level_off_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:      prdata = CFG_DATA_W'(mode_r);
      REG_PERIOD:    prdata = CFG_DATA_W'(period_r);
      REG_LEVEL_ON:  prdata = CFG_DATA_W'(level_on_r);
      REG_LEVEL_OFF: prdata = CFG_DATA_W'(level_off_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.mode      = mode_r;
  assign cfg.period_ms = period_r;
  assign cfg.level_on  = level_on_r;
  assign cfg.level_off = level_off_r;

endmodule

FILE: hw/rtl/rpg_cos_rom.sv
// ----------------------------------------------------------------------------
// rpg_cos_rom
// Raised-cosine factor table, Q1.16 in 0..65536, built at elaboration.
// ----------------------------------------------------------------------------
module rpg_cos_rom import rpg_pkg::*; #(
  parameter int ENTRIES = COS_ENTRIES_DFLT
) (
  input  logic                       clk,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [FACTOR_BITS-1:0]     rd_data
);

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic logic [FACTOR_BITS-1:0] rom_factor(input int unsigned k);
    logic [63:0] kk, r, s, x, x2, t, m, c, f30;
    logic [1:0]  q;
    logic        neg;
    kk = 64'(k) * 64'd4;
    q  = 2'(kk / 64'(ENTRIES));
    r  = kk % 64'(ENTRIES);
    s  = (q == 2'd1 || q == 2'd3) ? 64'(ENTRIES) - r : r;
    neg = (q == 2'd1 || q == 2'd2);
    x  = (s * HALF_PI_Q30) / 64'(ENTRIES);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    m  = ((x2 * t) >> 30) / 64'd90;
    t  = (m >= Q30_ONE) ? 64'd0 : Q30_ONE - m;
    m  = ((x2 * t) >> 30) / 64'd56;
    t  = (m >= Q30_ONE) ? 64'd0 : Q30_ONE - m;
    m  = ((x2 * t) >> 30) / 64'd30;
    t  = (m >= Q30_ONE) ? 64'd0 : Q30_ONE - m;
    m  = ((x2 * t) >> 30) / 64'd12;
    t  = (m >= Q30_ONE) ? 64'd0 : Q30_ONE - m;
    m  = ((x2 * t) >> 30) / 64'd2;
    t  = (m >= Q30_ONE) ? 64'd0 : Q30_ONE - m;
    c  = (t > Q30_ONE) ? Q30_ONE : t;
    f30 = neg ? (Q30_ONE - c) >> 1 : (Q30_ONE + c) >> 1;
    f30 = (f30 + 64'd8192) >> 14;
    return (f30 > 64'(FACTOR_ONE)) ? FACTOR_ONE : FACTOR_BITS'(f30);
  endfunction

  logic [FACTOR_BITS-1:0] rom_w [ENTRIES];
  logic [FACTOR_BITS-1:0] rd_data_r;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
    localparam logic [FACTOR_BITS-1:0] FACT = rom_factor(g);
    assign rom_w[g] = FACT;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= rom_w[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/rumble_pattern_generator_top.sv
// ----------------------------------------------------------------------------
// rumble_pattern_generator_top
// Two-channel rumble intensity generator with a millisecond phase counter.
// ----------------------------------------------------------------------------
// Each request optionally steps the phase one millisecond and returns one
// left/right intensity pair. Off, constant and pulse modes go from idle to
// done directly. In wave modes a radix-2 restoring divider forms the table
// index phase*COS_TABLE_ENTRIES/period one bit a cycle, then one table read
// and one shared multiplier used twice (left, then right) scale the level
// difference. The input is stalled while a request is in work; a finished
// pair sits in the output register and does not block taking the next
// request. The user writes configuration over APB only while no request is
// in work; the block does not enforce this. A period write at or below the
// current phase restarts the phase at zero. No clearing pass after reset.
module rumble_pattern_generator_top import rpg_pkg::*; #(
  parameter int COS_TABLE_ENTRIES = COS_ENTRIES_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_advance,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEVEL_BITS-1:0] out_left_level,
  output logic [LEVEL_BITS-1:0] out_right_level,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int QW   = $clog2(COS_TABLE_ENTRIES);
  localparam int DW   = PHASE_BITS + QW;
  localparam int CW   = $clog2(QW + 1);
  localparam int PW   = LEVEL_BITS + FACTOR_BITS;

  cfg_t cfg;

  state_t                 state_r, state_nxt;
  logic [PHASE_BITS-1:0]  phase_r, phase_nxt;
  logic [PHASE_BITS-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]          lo_r, lo_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [PW-1:0]          prod_r;
  logic [LEVEL_BITS-1:0]  left_r, right_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [LEVEL_BITS-1:0]  out_left_r, out_right_r;

  logic                   in_acc, is_wave;
  logic                   ld_div, div_step, mul_left, mul_right, add_right, load_out;
  logic [PHASE_BITS-1:0]  eff_period, phase_base, phase_inc;
  logic [DW-1:0]          scaled;
  logic [PHASE_BITS:0]    trial;
  logic                   trial_ge;
  logic [FACTOR_BITS-1:0] rom_data, fsel;
  logic [LEVEL_BITS-1:0]  diff, rnd, blended, res_left, res_right;
  logic                   on_ge, first_half;
  logic [PW-1:0]          prod_rnd;

  rpg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpg_cos_rom #(
    .ENTRIES (COS_TABLE_ENTRIES)
  ) u_rom (
    .clk     (clk),
    .rd_addr (lo_r),
    .rd_data (rom_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign is_wave  = (cfg.mode == MODE_SYNC_WAVE) || (cfg.mode == MODE_ALT_WAVE);

  // phase counter
  assign eff_period = (cfg.period_ms == '0) ? 16'd1 : cfg.period_ms;
  assign phase_base = (phase_r >= eff_period) ? '0 : phase_r;
  assign phase_inc  = phase_base + 16'd1;

  always_comb begin
    phase_nxt = phase_base;
    if (in_acc && in_advance) begin
      phase_nxt = (phase_inc >= eff_period) ? '0 : phase_inc;
    end
  end

  assign first_half = (phase_r < (eff_period >> 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = is_wave ? S_SCALE : S_DONE;
      S_SCALE: state_nxt = S_DIV;
      S_DIV:   if (cnt_r == '0) state_nxt = S_ROM;
      S_ROM:   state_nxt = S_MUL_L;
      S_MUL_L: state_nxt = S_MUL_R;
      S_MUL_R: state_nxt = S_ADD_R;
      S_ADD_R: state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ld_div    = (state_r == S_SCALE);
    div_step  = (state_r == S_DIV);
    mul_left  = (state_r == S_MUL_L);
    mul_right = (state_r == S_MUL_R);
    add_right = (state_r == S_ADD_R);
    load_out  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  end

  // radix-2 divider: quotient shifts into lo_r
  assign scaled   = DW'(phase_r) * DW'(COS_TABLE_ENTRIES);
  assign trial    = {rem_r, lo_r[QW-1]};
  assign trial_ge = (trial >= {1'b0, eff_period});

  always_comb begin
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    cnt_nxt = cnt_r;
    if (ld_div) begin
      rem_nxt = scaled[DW-1:QW];
      lo_nxt  = scaled[QW-1:0];
      cnt_nxt = CW'(QW - 1);
    end else if (div_step) begin
      rem_nxt = trial_ge ? PHASE_BITS'(trial - {1'b0, eff_period}) : trial[PHASE_BITS-1:0];
      lo_nxt  = {lo_r[QW-2:0], trial_ge};
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // shared multiplier and blend
  assign on_ge    = (cfg.level_on >= cfg.level_off);
  assign diff     = on_ge ? cfg.level_on - cfg.level_off : cfg.level_off - cfg.level_on;
  assign fsel     = mul_right ? FACTOR_ONE - rom_data : rom_data;
  assign prod_rnd = prod_r + PW'(32768);
  assign rnd      = prod_rnd[LEVEL_BITS+15:16];
  assign blended  = on_ge ? cfg.level_off + rnd : cfg.level_off - rnd;

  always_comb begin
    res_left  = '0;
    res_right = '0;
    unique case (mode_t'(cfg.mode))
      MODE_CONST: begin
        res_left  = cfg.level_on;
        res_right = cfg.level_off;
      end
      MODE_SYNC_PULSE: begin
        res_left  = first_half ? cfg.level_on : cfg.level_off;
        res_right = res_left;
      end
      MODE_ALT_PULSE: begin
        res_left  = first_half ? cfg.level_on : cfg.level_off;
        res_right = first_half ? cfg.level_off : cfg.level_on;
      end
      MODE_SYNC_WAVE, MODE_ALT_WAVE: begin
        res_left  = left_r;
        res_right = right_r;
      end
      default: begin
        res_left  = '0;
        res_right = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    if (mul_left || mul_right) begin
      prod_r <= PW'(diff) * PW'(fsel);
    end
    if (mul_right) begin
      left_r <= blended;
    end
    if (add_right) begin
      right_r <= (cfg.mode == MODE_SYNC_WAVE) ? left_r : blended;
    end
    if (load_out) begin
      out_left_r  <= res_left;
      out_right_r <= res_right;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_level  = out_left_r;
  assign out_right_level = out_right_r;

endmodule
